// ----- src/eps_pkg.sv -----
// ----------------------------------------------------------------------------
// eps_pkg: shared types and constants for the encoder position/speed block
// Command and status codes, register indexes, divider widths and the
// control bundle between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package eps_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SETREF = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNCAL = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	localparam logic [1:0] REG_POLARITY = 2'd0;
	localparam logic [1:0] REG_CPR      = 2'd1;
	localparam logic [1:0] REG_PERIOD   = 2'd2;

	localparam int CNT_W    = 16;                 // counter snapshot
	localparam int DELTA_W  = 17;
	localparam int TOTAL_W  = 64;
	localparam int RPM_W    = 32;
	localparam int CFG_W    = 24;
	localparam int OUT_DATA_W = 120;              // delta, total, rpm, padded to bytes

	// numerator = (mag * 60e6) << 17 plus den, below 2^59; divisor = 2*den
	localparam int PROD_W   = 41;
	localparam int SHIFT_W  = 17;
	localparam int NUM_W    = 59;
	localparam int DEN_W    = 49;
	localparam int ITER_W   = $clog2(NUM_W);
	localparam logic [25:0] SPEED_K = 26'd60000000;

	localparam logic [NUM_W-1:0] RPM_POS_LIM = NUM_W'(64'd2147483647);
	localparam logic [NUM_W-1:0] RPM_NEG_LIM = NUM_W'(64'd2147483648);

	typedef struct packed {
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

`default_nettype wire

// ----- src/eps_div.sv -----
// ----------------------------------------------------------------------------
// eps_div: shared restoring divider
// One quotient bit per cycle through a single subtract-and-compare unit;
// when the last bit is in, done pulses and the quotient holds.
// ----------------------------------------------------------------------------
`default_nettype none

module eps_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [eps_pkg::NUM_W-1:0] num,
	input  logic [eps_pkg::DEN_W-1:0] den,
	output eps_pkg::div_ctl_t        ctl,
	output logic [eps_pkg::NUM_W-1:0] quo
);
	import eps_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W+1:0]  diff;
	logic              take;

	// quo_q shifts numerator bits out of the top and quotient bits in below
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign take  = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ITER_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
	assign quo      = quo_q;

endmodule

`default_nettype wire

// ----- src/encoder_position_speed.sv -----
// ----------------------------------------------------------------------------
// encoder_position_speed: encoder position tracking and speed in rpm
// Input stream: tuser = command, tdata = 16-bit counter snapshot. One
// result per input on the output stream: tdata = delta, total, rpm_q8;
// tuser = speed status. Registers 0..2 (polarity, counts/rev Q16.8,
// period in us) are written over the cfg channel, always ready.
// Clear, set-reference, unused codes and uncalibrated samples finish in
// the accept cycle: the result is valid on the next cycle. A calibrated
// sample forms the denominator, product and numerator in the S_DEN,
// S_NUM and S_ADD states, then the shared divider produces the quotient
// one bit per cycle. One item is in flight at a time: a calibrated
// sample holds the input until its result enters the output register;
// other items can follow every cycle while the receiver takes results.
// s_tready is high only when the sequencer is idle and the output
// register is empty or being taken; a stalled receiver holds the result
// and, through that, the input. Reset clears state, total, snapshot,
// reference flag, registers and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_position_speed (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // counter
	input  logic [1:0]                     s_tuser,   // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [eps_pkg::OUT_DATA_W-1:0] m_tdata,   // delta, total, rpm_q8, zero pad
	output logic [1:0]                     m_tuser,   // speed_status
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [23:0]                    cfg_data
);
	import eps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEN,
		S_NUM,
		S_ADD,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	logic               pol_q;
	logic [CFG_W-1:0]   cpr_q;
	logic [CFG_W-1:0]   per_q;

	logic [CNT_W-1:0]   snap_q;
	logic               armed_q;
	logic [TOTAL_W-1:0] total_q;

	logic [DELTA_W-1:0] delta_q;
	logic               neg_q;
	logic [CNT_W-1:0]   mag_q;
	logic [2*CFG_W-1:0] den_q;
	logic [PROD_W-1:0]  prod_q;

	logic               out_free;
	logic               out_load;
	logic               in_acc;
	logic [CNT_W-1:0]   diff;
	logic [DELTA_W-1:0] d_raw;
	logic [DELTA_W-1:0] d_pol;
	logic [DELTA_W-1:0] d_smp;
	logic [DELTA_W-1:0] d_neg;
	logic [CNT_W-1:0]   mag;
	logic               uncal;
	logic [TOTAL_W-1:0] total_next;

	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	div_ctl_t           div_ctl;
	logic [NUM_W-1:0]   quo;
	logic               over;
	logic [RPM_W-1:0]   rpm_mag;
	logic [RPM_W-1:0]   rpm_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q <= 1'b0;
			cpr_q <= '0;
			per_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POLARITY: pol_q <= cfg_data[0];
				REG_CPR:      cpr_q <= cfg_data;
				REG_PERIOD:   per_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;

	// output register loads on an item that needs no division or at the end of a division
	assign out_load = (in_acc && !((s_tuser == CMD_SAMPLE) && !uncal))
		|| ((state_q == S_FIN) && out_free);

	// wrapped difference, sign taken from bit 15
	assign diff  = s_tdata - snap_q;
	assign d_raw = {diff[CNT_W-1], diff};
	assign d_pol = pol_q ? (~d_raw + 1'b1) : d_raw;
	assign d_smp = armed_q ? d_pol : '0;
	assign d_neg = ~d_smp + 1'b1;
	assign mag   = d_smp[DELTA_W-1] ? d_neg[CNT_W-1:0] : d_smp[CNT_W-1:0];
	assign uncal = (cpr_q == '0) || (per_q == '0);

	always_comb begin
		case (s_tuser)
			CMD_SAMPLE: total_next = total_q + {{(TOTAL_W-DELTA_W){d_smp[DELTA_W-1]}}, d_smp};
			CMD_CLEAR:  total_next = '0;
			CMD_SETREF: total_next = '0;
			default:    total_next = total_q;
		endcase
	end

	// rounded quotient: (2*mag*S + den) / (2*den)
	assign div_start = (state_q == S_ADD);
	assign div_num   = {prod_q, {SHIFT_W{1'b0}}} + NUM_W'(den_q);

	eps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({den_q, 1'b0}),
		.ctl    (div_ctl),
		.quo    (quo)
	);

	assign over    = neg_q ? (quo > RPM_NEG_LIM) : (quo > RPM_POS_LIM);
	assign rpm_mag = quo[RPM_W-1:0];
	assign rpm_val = neg_q ? (~rpm_mag + 1'b1) : rpm_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= ST_OK;
			snap_q   <= '0;
			armed_q  <= 1'b0;
			total_q  <= '0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						total_q <= total_next;
						case (s_tuser)
							CMD_SAMPLE: begin
								if (armed_q) begin
									snap_q <= s_tdata;
								end
							end
							CMD_SETREF: begin
								snap_q  <= s_tdata;
								armed_q <= 1'b1;
							end
							default: ;
						endcase
						if (s_tuser == CMD_SAMPLE && !uncal) begin
							state_q <= S_DEN;
						end else begin
							m_tdata  <= {{(OUT_DATA_W-RPM_W-TOTAL_W-DELTA_W){1'b0}},
								{RPM_W{1'b0}}, total_next,
								(s_tuser == CMD_SAMPLE) ? d_smp : {DELTA_W{1'b0}}};
							m_tuser  <= (s_tuser == CMD_SAMPLE) ? ST_UNCAL : ST_OK;
						end
					end
				end
				S_DEN: state_q <= S_NUM;
				S_NUM: state_q <= S_ADD;
				S_ADD: state_q <= S_DIV;
				S_DIV: begin
					if (div_ctl.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tdata  <= {{(OUT_DATA_W-RPM_W-TOTAL_W-DELTA_W){1'b0}},
							over ? {RPM_W{1'b0}} : rpm_val, total_q, delta_q};
						m_tuser  <= over ? ST_RANGE : ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			delta_q <= d_smp;
			neg_q   <= d_smp[DELTA_W-1];
			mag_q   <= mag;
		end
		if (state_q == S_DEN) begin
			den_q <= (2*CFG_W)'(cpr_q) * (2*CFG_W)'(per_q);
		end
		if (state_q == S_NUM) begin
			prod_q <= PROD_W'(mag_q) * PROD_W'(SPEED_K);
		end
	end

`ifndef ASSERT_OFF
	a_err_zero_rpm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata[112:81] == '0)
		else $error("speed error result with non-zero rpm");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.busy |-> !s_tready)
		else $error("input ready while divider busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_UNCAL || m_tuser == ST_RANGE))
		else $error("undefined speed status");

	a_div_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |=> div_ctl.busy)
		else $error("divider did not start");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for encoder_position_speed
// Counter snapshots and commands go in on the input stream. A behavioural
// tracker of snapshot, running total and speed predicts every reading, and
// each output transfer is checked field by field against the oldest
// prediction. The run opens with directed cases and then steps through a
// series of register settings with random, mostly well-formed runs.
// ----------------------------------------------------------------------------

module tb_top;

	import eps_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;                    // no effect on state
	localparam longint unsigned RPM_SCALE = 64'd3932160000000;  // 60 * 2^16 * 10^6
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] count;
	} enc_item_t;

	typedef struct packed {
		logic [16:0] delta;
		logic [63:0] total;
		logic [31:0] rpm;
		status_t     status;
	} reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;     // counter
	logic [1:0]            s_tuser = '0;     // cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // delta, total, rpm_q8, zero pad
	logic [1:0]            m_tuser;          // speed_status
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [23:0]           cfg_data = '0;

	encoder_position_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	enc_item_t counter_items[$];
	reading_t  expected_readings[$];

	// tracker state and register copies
	logic        set_polarity = 1'b0;
	logic [23:0] set_cpr = '0;
	logic [23:0] set_period = '0;
	logic [15:0] enc_snap = '0;
	logic [63:0] enc_total = '0;
	logic        enc_armed = 1'b0;

	logic calm = 1'b0;
	int   err_count = 0;
	int   n_items = 0;
	int   n_checked = 0;
	int   n_settings = 0;
	int   n_status[3] = '{0, 0, 0};
	int   send_gap = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;

	function automatic void rpm_of_delta(input int d, output logic [31:0] rpm,
	                                     output status_t st);
		longint unsigned den, mag, q, lim;
		rpm = '0;
		st = ST_OK;
		if (set_cpr == '0 || set_period == '0) begin
			st = ST_UNCAL;
			return;
		end
		den = 64'(set_cpr) * 64'(set_period);
		mag = (d < 0) ? longint'(-d) : longint'(d);
		// round half away from zero on the magnitude
		q = (2 * mag * RPM_SCALE + den) / (2 * den);
		lim = (d < 0) ? 64'd2147483648 : 64'd2147483647;
		if (q > lim) begin
			st = ST_RANGE;
			return;
		end
		rpm = (d < 0) ? 32'(64'd0 - q) : q[31:0];
	endfunction

	function automatic reading_t track_encoder(input logic [1:0] cmd, input logic [15:0] count);
		reading_t    r;
		logic [15:0] diff;
		int          d;
		d = 0;
		r.rpm = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_SAMPLE: begin
				if (enc_armed) begin
					diff = count - enc_snap;
					d = diff[15] ? int'(diff) - 65536 : int'(diff);
					if (set_polarity)
						d = -d;
					enc_snap = count;
					enc_total = enc_total + 64'(longint'(d));
				end
				rpm_of_delta(d, r.rpm, r.status);
			end
			CMD_CLEAR: enc_total = '0;
			CMD_SETREF: begin
				enc_snap = count;
				enc_total = '0;
				enc_armed = 1'b1;
			end
			default: ;
		endcase
		r.delta = 17'(d);
		r.total = enc_total;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin : drive
		enc_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(track_encoder(s_tuser, s_tdata));
				n_items++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (counter_items.size() > 0) begin
					it = counter_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= it.cmd;
					s_tdata <= it.count;
					if (!calm && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 16);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin : monitor
		reading_t    want;
		logic [16:0] got_delta;
		logic [63:0] got_total;
		logic [31:0] got_rpm;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_delta = m_tdata[16:0];
				got_total = m_tdata[80:17];
				got_rpm = m_tdata[112:81];
				if (m_tuser < 2'd3)
					n_status[m_tuser]++;
				if (expected_readings.size() == 0) begin
					$error("result transfer with no reading expected");
					err_count++;
				end else begin
					want = expected_readings.pop_front();
					n_checked++;
					if (got_delta !== want.delta) begin
						$error("delta: expected %0d, got %0d", $signed(want.delta),
						       $signed(got_delta));
						err_count++;
					end
					if (got_total !== want.total) begin
						$error("total: expected %0d, got %0d", $signed(want.total),
						       $signed(got_total));
						err_count++;
					end
					if (got_rpm !== want.rpm) begin
						$error("rpm_q8: expected %0d, got %0d", $signed(want.rpm),
						       $signed(got_rpm));
						err_count++;
					end
					if (m_tuser !== want.status) begin
						$error("speed_status: expected %0d, got %0d", want.status, m_tuser);
						err_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					stall_left <= $urandom_range(1, 16);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] cmd, input logic [15:0] count);
		counter_items.push_back('{cmd: cmd, count: count});
	endtask

	// everything sent, every reading back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (counter_items.size() > 0 || s_tvalid || expected_readings.size() > 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POLARITY: set_polarity = val[0];
			REG_CPR:      set_cpr = val;
			REG_PERIOD:   set_period = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic pol, input logic [23:0] cpr,
	                             input logic [23:0] period);
		wait_idle();
		write_reg(REG_POLARITY, {23'd0, pol});
		write_reg(REG_CPR, cpr);
		write_reg(REG_PERIOD, period);
		n_settings++;
	endtask

	// random run: mostly samples near the last snapshot, with extremes and noise
	task automatic queue_random_run(input int n);
		logic [15:0] base;
		int          pick;
		int          step;
		base = 16'($urandom);
		push_item(CMD_SETREF, base);
		for (int k = 1; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				base = 16'($urandom);
				push_item(CMD_SETREF, base);
			end else if (pick < 7) begin
				push_item(CMD_CLEAR, 16'($urandom));
			end else if (pick < 9) begin
				push_item(CMD_UNUSED, 16'($urandom));
			end else if (pick < 20) begin
				base = 16'($urandom);
				push_item(CMD_SAMPLE, base);
			end else if (pick < 28) begin
				// half-turn of the counter: +/-32767 and the -32768 wrap point
				base = base + 16'($urandom_range(32767, 32769));
				push_item(CMD_SAMPLE, base);
			end else begin
				step = $urandom_range(0, 400) - 200;
				base = base + 16'(step);
				push_item(CMD_SAMPLE, base);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset value: uncalibrated, and nothing referenced yet
		push_item(CMD_SAMPLE, 16'h0000);
		push_item(CMD_SAMPLE, 16'hFFFF);
		push_item(CMD_CLEAR, 16'h1234);
		push_item(CMD_UNUSED, 16'hABCD);
		push_item(CMD_SETREF, 16'h0000);
		push_item(CMD_SAMPLE, 16'h7FFF);
		push_item(CMD_SAMPLE, 16'hFFFF);
		push_item(CMD_SAMPLE, 16'hFFFF);
		push_item(CMD_CLEAR, 16'h0000);
		push_item(CMD_SAMPLE, 16'h0000);

		// den 6e7: a delta of 32768 lands exactly on 2^31
		apply_setting(1'b1, 24'd60000, 24'd1000);
		push_item(CMD_SETREF, 16'h0000);
		push_item(CMD_SAMPLE, 16'h8000);
		push_item(CMD_SAMPLE, 16'h0001);
		push_item(CMD_SAMPLE, 16'h0001);
		apply_setting(1'b0, 24'd60000, 24'd1000);
		push_item(CMD_SETREF, 16'h0000);
		push_item(CMD_SAMPLE, 16'h8000);

		// den = 2 * scale: odd deltas give exact half-way results
		apply_setting(1'b0, 24'd12582912, 24'd625000);
		push_item(CMD_SAMPLE, 16'h8001);
		push_item(CMD_SAMPLE, 16'h8000);
		push_item(CMD_SAMPLE, 16'h8003);
		push_item(CMD_SAMPLE, 16'h8000);
		apply_setting(1'b1, 24'hFFFFFF, 24'hFFFFFF);
		push_item(CMD_SAMPLE, 16'h0000);
		push_item(CMD_SAMPLE, 16'h7FFF);
		apply_setting(1'b0, 24'd1, 24'd1);
		push_item(CMD_SAMPLE, 16'h8000);
		push_item(CMD_SAMPLE, 16'h8000);

		apply_setting(1'b0, 24'd262144, 24'd1000);
		queue_random_run(103);
		apply_setting(1'b1, 24'd128000, 24'd250);
		queue_random_run(103);
		apply_setting(1'b0, 24'd0, 24'd1000);
		queue_random_run(103);
		apply_setting(1'b1, 24'd512000, 24'd0);
		queue_random_run(103);
		apply_setting(1'b0, 24'hFFFFFF, 24'hFFFFFF);
		queue_random_run(103);
		apply_setting(1'b1, 24'd1, 24'd1);
		queue_random_run(103);
		for (int k = 0; k < 2; k++) begin
			apply_setting(1'($urandom), 24'($urandom_range(1, 24'hFFFFFF)),
			              24'($urandom_range(1, 24'hFFFFFF)));
			queue_random_run(103);
		end
		apply_setting(1'b0, 24'd60000, 24'd1000);
		queue_random_run(103);
		// closing stretch at full rate on both sides
		apply_setting(1'b1, 24'd1048576, 24'd500);
		calm = 1'b1;
		queue_random_run(103);

		wait_idle();
		repeat (80) @(posedge clk);

		$display("tb_top: %0d items over %0d register settings, %0d readings checked",
		         n_items, n_settings, n_checked);
		$display("tb_top: status ok %0d, uncalibrated %0d, out of range %0d",
		         n_status[0], n_status[1], n_status[2]);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
